// ----- hdl/utf8cw_pkg.sv -----
// Shared types and constants for the UTF-8 decoder with cell widths.
package utf8cw_pkg;

    // Width of the internal running cell-width sum; it saturates at all ones.
    localparam int TOTAL_WIDTH_BITS = 16;

    // Queue between front and back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    // Most results that one input byte can cause.
    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        malformed;
        logic [1:0]  cell_width;
        logic [15:0] running_width;
        logic        string_done;
        logic        last_of_run;
    } out_t;

    // One decoded code point before widths are applied.
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  cnt;
        logic        bad;
    } item_t;

    // All results caused by one input byte.
    typedef struct packed {
        item_t [MAX_RESULTS-1:0] items;
        logic  [2:0]             count;
        logic                    eos;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ----- hdl/utf8cw_front.sv -----
// Front end: byte intake, sequence assembly, validity checks and run building.
module utf8cw_front
    import utf8cw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  in_t         byte_data,
    input  queue_stat_t qstat,
    output logic        push,
    output run_t        push_run
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] exp_len_reg, exp_len_next;

    logic        accept;
    logic [7:0]  b;
    logic        eos;
    logic        idle;
    logic        is_cont;
    logic        complete;
    logic [2:0]  lead_len;
    logic        fresh_hold;
    item_t       fresh_item;
    item_t       tail_item;
    logic        tail_has;
    logic        replay;
    logic [20:0] v;
    logic        v_bad;
    logic [2:0]  n;

    function automatic item_t raw_item(input logic [7:0] x);
        item_t r;
        r.cp  = 21'(x);
        r.cnt = 3'd1;
        r.bad = 1'b1;
        return r;
    endfunction

    assign b          = byte_data.data_byte;
    assign eos        = byte_data.end_of_string;
    assign byte_ready = !qstat.full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        if (b[7:5] == 3'b110)
            lead_len = 3'd2;
        else if (b[7:4] == 4'b1110)
            lead_len = 3'd3;
        else if (b[7:3] == 5'b11110)
            lead_len = 3'd4;
        else
            lead_len = 3'd0;
    end

    assign idle     = (held_count_reg == 2'd0) || (exp_len_reg < 3'd2) ||
                      ({1'b0, held_count_reg} >= exp_len_reg);
    assign is_cont  = (b[7:6] == 2'b10);
    assign complete = (({1'b0, held_count_reg} + 3'd1) == exp_len_reg);

    // A fresh byte either starts a held sequence or gives one result.
    assign fresh_hold = b[7] && (lead_len != 3'd0) && !eos;
    always_comb
    begin
        fresh_item.cp  = 21'(b);
        fresh_item.cnt = 3'd1;
        fresh_item.bad = b[7];
    end

    always_comb
    begin
        unique case (exp_len_reg)
            3'd2:    v = 21'({held_reg[0][4:0], b[5:0]});
            3'd3:    v = 21'({held_reg[0][3:0], held_reg[1][5:0], b[5:0]});
            default: v = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0], b[5:0]};
        endcase
        unique case (exp_len_reg)
            3'd2:    v_bad = (v < 21'h80);
            3'd3:    v_bad = (v < 21'h800) || ((v >= 21'hd800) && (v <= 21'hdfff));
            default: v_bad = (v < 21'h10000) || (v > 21'h10ffff);
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            held_next[i] = held_reg[i];
        end
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        push_run        = '0;
        tail_item       = fresh_item;
        tail_has        = 1'b0;
        replay          = 1'b0;
        n               = 3'd0;

        if (idle)
        begin
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
            if (fresh_hold)
            begin
                held_next[0]    = b;
                held_count_next = 2'd1;
                exp_len_next    = lead_len;
            end
            else
            begin
                push_run.items[0] = fresh_item;
                n                 = 3'd1;
            end
        end
        else if (!is_cont)
        begin
            // Drop the pending sequence as raw bytes, then decode this byte fresh.
            replay          = 1'b1;
            tail_item       = fresh_item;
            tail_has        = !fresh_hold;
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
            if (fresh_hold)
            begin
                held_next[0]    = b;
                held_count_next = 2'd1;
                exp_len_next    = lead_len;
            end
        end
        else if (complete)
        begin
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
            if (v_bad)
            begin
                replay    = 1'b1;
                tail_item = raw_item(b);
                tail_has  = 1'b1;
            end
            else
            begin
                push_run.items[0].cp  = v;
                push_run.items[0].cnt = exp_len_reg;
                push_run.items[0].bad = 1'b0;
                n                     = 3'd1;
            end
        end
        else if (eos)
        begin
            replay    = 1'b1;
            tail_item = raw_item(b);
            tail_has  = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) == held_count_reg)
                    held_next[i] = b;
            end
            held_count_next = held_count_reg + 2'd1;
        end

        if (replay)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < held_count_reg)
                    push_run.items[i] = raw_item(held_reg[i]);
            end
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                if (3'(i) == {1'b0, held_count_reg})
                    push_run.items[i] = tail_item;
            end
            n = {1'b0, held_count_reg} + 3'(tail_has);
        end

        if (eos)
        begin
            held_count_next = 2'd0;
            exp_len_next    = 3'd0;
        end

        push_run.count = n;
        push_run.eos   = eos;
    end

    assign push = accept && (n != 3'd0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    // A pending sequence always has room for at least one more byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd0) |-> ((exp_len_reg >= 3'd2) && (exp_len_reg <= 3'd4) &&
                                      ({1'b0, held_count_reg} < exp_len_reg)))
        else $error("front: held count out of step with sequence length");

endmodule

// ----- hdl/utf8cw_queue.sv -----
// Short run queue that decouples the front end from the result stage.
module utf8cw_queue
    import utf8cw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  run_t        push_run,
    input  logic        pop,
    output run_t        head,
    output queue_stat_t qstat
);

    run_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !qstat.full)
        else $error("queue: push while full");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !qstat.empty)
        else $error("queue: pop while empty");

endmodule

// ----- hdl/utf8cw_back.sv -----
// Result stage: walks each run, assigns cell widths and keeps the string sum.
module utf8cw_back
    import utf8cw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  run_t        head,
    input  queue_stat_t qstat,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output out_t        result_data
);

    logic                        out_valid_reg, out_valid_next;
    out_t                        out_reg;
    out_t                        out_next;
    logic [1:0]                  idx_reg, idx_next;
    logic [TOTAL_WIDTH_BITS-1:0] total_reg, total_next;

    logic                        load;
    item_t                       item;
    logic                        is_last;
    logic [1:0]                  cw;
    logic [TOTAL_WIDTH_BITS:0]   sum_wide;
    logic [TOTAL_WIDTH_BITS-1:0] sum_sat;

    function automatic logic [1:0] cells_of(input logic [20:0] c);
        logic [1:0] w;
        w = 2'd1;
        if ((c < 21'h20) || ((c >= 21'h7f) && (c < 21'ha0)))
            w = 2'd0;
        else if (((c >= 21'h0300) && (c <= 21'h036f)) ||
                 ((c >= 21'h1ab0) && (c <= 21'h1aff)) ||
                 ((c >= 21'h1dc0) && (c <= 21'h1dff)) ||
                 ((c >= 21'h20d0) && (c <= 21'h20ff)) ||
                 ((c >= 21'hfe20) && (c <= 21'hfe2f)))
            w = 2'd0;
        else if (((c >= 21'h1100) && (c <= 21'h115f)) ||
                 (c == 21'h2329) || (c == 21'h232a) ||
                 ((c >= 21'h2e80) && (c <= 21'h303e)) ||
                 ((c >= 21'h3040) && (c <= 21'ha4cf)) ||
                 ((c >= 21'hac00) && (c <= 21'hd7a3)) ||
                 ((c >= 21'hf900) && (c <= 21'hfaff)) ||
                 ((c >= 21'hfe10) && (c <= 21'hfe19)) ||
                 ((c >= 21'hfe30) && (c <= 21'hfe6f)) ||
                 ((c >= 21'hff00) && (c <= 21'hff60)) ||
                 ((c >= 21'hffe0) && (c <= 21'hffe6)) ||
                 ((c >= 21'h1f300) && (c <= 21'h1faff)))
            w = 2'd2;
        return w;
    endfunction

    assign load     = !qstat.empty && (!out_valid_reg || result_ready);
    assign item     = head.items[idx_reg];
    assign is_last  = (({1'b0, idx_reg} + 3'd1) == head.count);
    assign cw       = cells_of(item.cp);
    assign sum_wide = {1'b0, total_reg} + (TOTAL_WIDTH_BITS + 1)'(cw);
    assign sum_sat  = sum_wide[TOTAL_WIDTH_BITS] ? '1 : sum_wide[TOTAL_WIDTH_BITS-1:0];
    assign pop      = load && is_last;

    always_comb
    begin
        out_next.code_point    = item.cp;
        out_next.byte_count    = item.cnt;
        out_next.malformed     = item.bad;
        out_next.cell_width    = cw;
        out_next.running_width = 16'(sum_sat);
        out_next.string_done   = is_last && head.eos;
        out_next.last_of_run   = is_last;

        out_valid_next = out_valid_reg && !result_ready;
        idx_next       = idx_reg;
        total_next     = total_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
            // Clear the sum once the string's final code point is out.
            total_next     = (is_last && head.eos) ? '0 : sum_sat;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            total_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (({1'b0, idx_reg} < head.count) && (head.count != 3'd0)))
        else $error("back: run index beyond run length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.string_done) |-> out_reg.last_of_run)
        else $error("back: string end not on last result of a beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last && head.eos) |=> (total_reg == '0))
        else $error("back: width sum not cleared at end of string");

endmodule

// ----- hdl/utf8_decoder_cell_width.sv -----
// UTF-8 decoder top level: front end, run queue and result stage.
// Takes one byte per beat and returns one result per decoded code point, with the
// terminal cell width and a saturating per-string width sum. The front end accepts a
// byte every cycle while the two-entry run queue has room; a byte that gives results
// is held in the run queue and then in the registered output stage. The result
// stage emits one result per cycle while result_ready is high; a byte that
// completes a sequence or is plain ASCII gives one result, one that only extends a
// pending sequence gives none, and a malformed or truncated sequence gives one result
// per replayed byte (up to four per input byte) while the queue fills and intake stalls.
module utf8_decoder_cell_width
    import utf8cw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    output logic byte_ready,
    input  in_t  byte_data,
    output logic result_valid,
    input  logic result_ready,
    output out_t result_data
);

    logic        push;
    logic        pop;
    run_t        push_run;
    run_t        head;
    queue_stat_t qstat;

    utf8cw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .qstat      (qstat),
        .push       (push),
        .push_run   (push_run)
    );

    utf8cw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    utf8cw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule
